// ===== rtl/imrot_pkg.sv =====
// Shared constants, codes and types for the image rotator.
// No dependencies; used by the channel interfaces and the top level.
package imrot_pkg;

    // Frame geometry and number formats
    localparam int MAX_SIDE       = 512;
    localparam int COORD_W        = $clog2(MAX_SIDE);
    localparam int SIDE_W         = COORD_W + 1;
    localparam int ADDR_W         = 2 * COORD_W;
    localparam int PIXEL_BITS     = 32;
    localparam int TRIG_FRAC_BITS = 14;
    localparam int TRIG_W         = 16;

    // Configuration port
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 5;

    // Register reset values
    localparam logic signed [TRIG_W-1:0] COS_RESET    = 16'sd16384;
    localparam logic signed [TRIG_W-1:0] SIN_RESET    = 16'sd0;
    localparam logic [COORD_W-1:0]       CENTER_RESET = COORD_W'(256);
    localparam logic [SIDE_W-1:0]        SIDE_RESET   = SIDE_W'(MAX_SIDE);

    // Request kinds
    typedef enum logic {
        REQ_LOAD  = 1'b0,
        REQ_FETCH = 1'b1
    } req_kind_t;

    // Register indexes
    typedef enum logic [2:0] {
        REG_COS          = 3'd0,
        REG_SIN          = 3'd1,
        REG_CENTER_COL   = 3'd2,
        REG_CENTER_ROW   = 3'd3,
        REG_FRAME_WIDTH  = 3'd4,
        REG_FRAME_HEIGHT = 3'd5
    } cfg_reg_t;

endpackage

// ===== rtl/imrot_if.sv =====
// Valid/ready channel interfaces for rotator requests and results.
// Depends on imrot_pkg for field widths.
interface imrot_req_if;
    logic                             valid;
    logic                             ready;
    logic                             req_type;
    logic [imrot_pkg::COORD_W-1:0]    col;
    logic [imrot_pkg::COORD_W-1:0]    row;
    logic [imrot_pkg::PIXEL_BITS-1:0] pixel_in;

    modport source (output valid, req_type, col, row, pixel_in, input ready);
    modport sink   (input valid, req_type, col, row, pixel_in, output ready);
endinterface

interface imrot_res_if;
    logic                             valid;
    logic                             ready;
    logic [imrot_pkg::PIXEL_BITS-1:0] pixel_out;
    logic                             inside_res;

    modport source (output valid, pixel_out, inside_res, input ready);
    modport sink   (input valid, pixel_out, inside_res, output ready);
endinterface

// ===== rtl/image_rotate_nearest.sv =====
// Image rotator top level: frame store plus inverse-mapping nearest-neighbor lookup.
// A fetch result leaves through the stage 5 register after its request has passed stages 1 to 4.
// Throughput: one transaction per cycle while no held result stalls the pipeline, set by
// the single-port frame store that serves one load write or one fetch read each cycle in stage 5.
// Reset (rst_n, async low): clears pipeline valids and background, sets the configuration registers
// to their reset values; frame store contents stay undefined until loaded. Depends on imrot_pkg, imrot_if.
module image_rotate_nearest (
    input  logic                                clk,
    input  logic                                rst_n,
    imrot_req_if.sink                           req,
    imrot_res_if.source                         res,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [imrot_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [imrot_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [imrot_pkg::APB_DATA_W-1:0]    prdata,
    output logic                                pready
);

    localparam int COORD_W = imrot_pkg::COORD_W;
    localparam int SIDE_W  = imrot_pkg::SIDE_W;
    localparam int ADDR_W  = imrot_pkg::ADDR_W;
    localparam int PIX_W   = imrot_pkg::PIXEL_BITS;
    localparam int FRAC    = imrot_pkg::TRIG_FRAC_BITS;
    localparam int TRIG_W  = imrot_pkg::TRIG_W;
    localparam int DATA_W  = imrot_pkg::APB_DATA_W;
    localparam int OFS_W   = COORD_W + 2;
    localparam int PROD_W  = OFS_W + TRIG_W;
    localparam int T_W     = PROD_W + 2;
    localparam int MAP_W   = T_W - (FRAC + 1);
    localparam int SRC_W   = MAP_W + 1;
    localparam logic signed [T_W-1:0] HALF_UNIT = T_W'(1) <<< FRAC;

    typedef struct packed {
        logic                   kind;
        logic [COORD_W-1:0]     col;
        logic [COORD_W-1:0]     row;
        logic [PIX_W-1:0]       pixel;
    } item_t;

    // Configuration registers
    logic signed [TRIG_W-1:0] cos_reg;
    logic signed [TRIG_W-1:0] sin_reg;
    logic [COORD_W-1:0]       center_col_reg;
    logic [COORD_W-1:0]       center_row_reg;
    logic [SIDE_W-1:0]        frame_width_reg;
    logic [SIDE_W-1:0]        frame_height_reg;
    imrot_pkg::cfg_reg_t      cfg_idx;
    logic                     cfg_wr;

    // Pipeline stages
    logic                     vld1_reg, vld2_reg, vld3_reg, vld4_reg, vld5_reg;
    logic                     en1, en2, en3, en4, en5;
    item_t                    s1_reg, s2_reg, s3_reg;
    logic signed [OFS_W-1:0]  du1_reg, dv1_reg;
    logic signed [OFS_W-1:0]  du_next, dv_next;
    logic signed [COORD_W:0]  dcol, drow;
    logic signed [PROD_W-1:0] pcu_reg, psv_reg, psu_reg, pcv_reg;
    logic signed [PROD_W-1:0] pcu_next, psv_next, psu_next, pcv_next;
    logic signed [T_W-1:0]    tu, tv;
    logic signed [MAP_W-1:0]  mcol_reg, mrow_reg;
    logic signed [SRC_W-1:0]  src_col, src_row;
    logic [SIDE_W-1:0]        width_lim, height_lim;
    logic [SIDE_W-1:0]        height_m1;
    logic                     inside_next, bgcap_next;
    logic [ADDR_W-1:0]        addr_next;
    logic                     kind4_reg, inside4_reg, bgcap4_reg;
    logic [ADDR_W-1:0]        addr4_reg;
    logic [PIX_W-1:0]         pixel4_reg;
    logic [PIX_W-1:0]         rdata_reg, bg5_reg, background_reg;
    logic                     inside5_reg;

    logic [PIX_W-1:0]         frame_mem [imrot_pkg::MAX_SIDE * imrot_pkg::MAX_SIDE];

    // Decode the configuration port
    assign pready  = 1'b1;
    assign cfg_idx = imrot_pkg::cfg_reg_t'(paddr[4:2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cos_reg          <= imrot_pkg::COS_RESET;
            sin_reg          <= imrot_pkg::SIN_RESET;
            center_col_reg   <= imrot_pkg::CENTER_RESET;
            center_row_reg   <= imrot_pkg::CENTER_RESET;
            frame_width_reg  <= imrot_pkg::SIDE_RESET;
            frame_height_reg <= imrot_pkg::SIDE_RESET;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                imrot_pkg::REG_COS:          cos_reg          <= pwdata[TRIG_W-1:0];
                imrot_pkg::REG_SIN:          sin_reg          <= pwdata[TRIG_W-1:0];
                imrot_pkg::REG_CENTER_COL:   center_col_reg   <= pwdata[COORD_W-1:0];
                imrot_pkg::REG_CENTER_ROW:   center_row_reg   <= pwdata[COORD_W-1:0];
                imrot_pkg::REG_FRAME_WIDTH:  frame_width_reg  <= pwdata[SIDE_W-1:0];
                imrot_pkg::REG_FRAME_HEIGHT: frame_height_reg <= pwdata[SIDE_W-1:0];
                default: ;
            endcase
        end
    end

    // Return register contents on reads
    always_comb
    begin
        unique case (cfg_idx)
            imrot_pkg::REG_COS:          prdata = DATA_W'(cos_reg);
            imrot_pkg::REG_SIN:          prdata = DATA_W'(sin_reg);
            imrot_pkg::REG_CENTER_COL:   prdata = DATA_W'(center_col_reg);
            imrot_pkg::REG_CENTER_ROW:   prdata = DATA_W'(center_row_reg);
            imrot_pkg::REG_FRAME_WIDTH:  prdata = DATA_W'(frame_width_reg);
            imrot_pkg::REG_FRAME_HEIGHT: prdata = DATA_W'(frame_height_reg);
            default:                     prdata = '0;
        endcase
    end

    // Advance each stage when it is empty or its successor moves
    assign en5       = !vld5_reg || res.ready;
    assign en4       = !vld4_reg || en5;
    assign en3       = !vld3_reg || en4;
    assign en2       = !vld2_reg || en3;
    assign en1       = !vld1_reg || en2;
    assign req.ready = en1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
            vld3_reg <= 1'b0;
            vld4_reg <= 1'b0;
            vld5_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                vld1_reg <= req.valid;
            end
            if (en2)
            begin
                vld2_reg <= vld1_reg;
            end
            if (en3)
            begin
                vld3_reg <= vld2_reg;
            end
            if (en4)
            begin
                vld4_reg <= vld3_reg;
            end
            if (en5)
            begin
                vld5_reg <= vld4_reg && (kind4_reg == imrot_pkg::REQ_FETCH);
            end
        end
    end

    // Stage 1: capture request, form odd-centered offsets 2*(v-c)+1
    assign dcol    = $signed({1'b0, req.col}) - $signed({1'b0, center_col_reg});
    assign drow    = $signed({1'b0, req.row}) - $signed({1'b0, center_row_reg});
    assign du_next = {dcol, 1'b1};
    assign dv_next = {drow, 1'b1};

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            s1_reg.kind  <= req.req_type;
            s1_reg.col   <= req.col;
            s1_reg.row   <= req.row;
            s1_reg.pixel <= req.pixel_in;
            du1_reg      <= du_next;
            dv1_reg      <= dv_next;
        end
    end

    // Stage 2: four rotation products
    always_comb
    begin
        pcu_next = PROD_W'(du1_reg) * PROD_W'(cos_reg);
        psv_next = PROD_W'(dv1_reg) * PROD_W'(sin_reg);
        psu_next = PROD_W'(du1_reg) * PROD_W'(sin_reg);
        pcv_next = PROD_W'(dv1_reg) * PROD_W'(cos_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en2)
        begin
            s2_reg  <= s1_reg;
            pcu_reg <= pcu_next;
            psv_reg <= psv_next;
            psu_reg <= psu_next;
            pcv_reg <= pcv_next;
        end
    end

    // Stage 3: combine products, remove the half offset and floor-halve
    assign tu = T_W'(pcu_reg) - T_W'(psv_reg) - HALF_UNIT;
    assign tv = T_W'(psu_reg) + T_W'(pcv_reg) - HALF_UNIT;

    always_ff @(posedge clk)
    begin
        if (en3)
        begin
            s3_reg   <= s2_reg;
            mcol_reg <= tu[T_W-1:FRAC+1];
            mrow_reg <= tv[T_W-1:FRAC+1];
        end
    end

    // Stage 4: add the center back, bounds check, pick the store address
    assign src_col    = SRC_W'(mcol_reg) + SRC_W'($signed({1'b0, center_col_reg}));
    assign src_row    = SRC_W'(mrow_reg) + SRC_W'($signed({1'b0, center_row_reg}));
    assign width_lim  = (frame_width_reg > SIDE_W'(imrot_pkg::MAX_SIDE))
                        ? SIDE_W'(imrot_pkg::MAX_SIDE) : frame_width_reg;
    assign height_lim = (frame_height_reg > SIDE_W'(imrot_pkg::MAX_SIDE))
                        ? SIDE_W'(imrot_pkg::MAX_SIDE) : frame_height_reg;
    assign height_m1  = frame_height_reg - SIDE_W'(1);

    always_comb
    begin
        inside_next = !src_col[SRC_W-1] && !src_row[SRC_W-1]
                      && (src_col[SRC_W-2:0] < (SRC_W-1)'(width_lim))
                      && (src_row[SRC_W-2:0] < (SRC_W-1)'(height_lim));
        bgcap_next  = (s3_reg.col == '0) && (frame_height_reg != '0)
                      && ({1'b0, s3_reg.row} == height_m1);
        if (s3_reg.kind == imrot_pkg::REQ_FETCH)
        begin
            addr_next = {src_row[COORD_W-1:0], src_col[COORD_W-1:0]};
        end
        else
        begin
            addr_next = {s3_reg.row, s3_reg.col};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en4)
        begin
            kind4_reg   <= s3_reg.kind;
            pixel4_reg  <= s3_reg.pixel;
            addr4_reg   <= addr_next;
            inside4_reg <= inside_next;
            bgcap4_reg  <= bgcap_next;
        end
    end

    // Stage 5: frame store access, write for loads and registered read for fetches
    always_ff @(posedge clk)
    begin
        if (en5 && vld4_reg)
        begin
            if (kind4_reg == imrot_pkg::REQ_LOAD)
            begin
                frame_mem[addr4_reg] <= pixel4_reg;
            end
            else
            begin
                rdata_reg <= frame_mem[addr4_reg];
            end
        end
    end

    // Capture the background pixel in stream order with the store writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            background_reg <= '0;
        end
        else if (en5 && vld4_reg && (kind4_reg == imrot_pkg::REQ_LOAD) && bgcap4_reg)
        begin
            background_reg <= pixel4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en5)
        begin
            bg5_reg     <= background_reg;
            inside5_reg <= inside4_reg;
        end
    end

    // Drive the result channel
    assign res.valid      = vld5_reg;
    assign res.pixel_out  = inside5_reg ? rdata_reg : bg5_reg;
    assign res.inside_res = inside5_reg;

`ifndef ASSERT_OFF
    // A load leaving stage 4 never shows up as a result
    assert property (@(posedge clk) disable iff (!rst_n)
        (vld4_reg && (kind4_reg == imrot_pkg::REQ_LOAD) && en5) |=> !vld5_reg)
        else $error("load produced a result");

    // A stalled result keeps its frame store read data
    assert property (@(posedge clk) disable iff (!rst_n)
        (vld5_reg && !res.ready) |=> $stable(rdata_reg))
        else $error("read data changed under stall");

    // Requests are refused only when every stage is occupied
    assert property (@(posedge clk) disable iff (!rst_n)
        !req.ready |-> (vld1_reg && vld2_reg && vld3_reg && vld4_reg && vld5_reg))
        else $error("pipeline refused a request with a free stage");
`endif

endmodule

// ===== tb/sv/imrot_tb_pkg.sv =====
// Test-side register record and source-coordinate mapping for the image rotator.
// Depends on imrot_pkg; used by the checker and the testbench top.
package imrot_tb_pkg;
    import imrot_pkg::*;

    localparam int TRIG_ONE = 1 << TRIG_FRAC_BITS;

    typedef struct packed {
        logic signed [TRIG_W-1:0] cos_v;
        logic signed [TRIG_W-1:0] sin_v;
        logic [COORD_W-1:0]       center_col;
        logic [COORD_W-1:0]       center_row;
        logic [SIDE_W-1:0]        width;
        logic [SIDE_W-1:0]        height;
    } rot_cfg_t;

    // Register values right after reset
    function automatic rot_cfg_t cfg_reset();
        rot_cfg_t c;
        c.cos_v      = COS_RESET;
        c.sin_v      = SIN_RESET;
        c.center_col = CENTER_RESET;
        c.center_row = CENTER_RESET;
        c.width      = SIDE_RESET;
        c.height     = SIDE_RESET;
        return c;
    endfunction

    // Map a destination pixel back to its source; return 1 when it lands in the frame
    function automatic bit map_source(input rot_cfg_t c,
                                      input logic [COORD_W-1:0] col,
                                      input logic [COORD_W-1:0] row,
                                      output int src_col, output int src_row);
        longint pc, pr, cc, cr, kc, ks, du, dv, ru, rv, w, h, half;
        pc = col;
        pr = row;
        cc = c.center_col;
        cr = c.center_row;
        kc = $signed(c.cos_v);
        ks = $signed(c.sin_v);
        half = longint'(TRIG_ONE);
        // odd-centred offsets, rotated exactly in Q1.F
        du = 2 * (pc - cc) + 1;
        dv = 2 * (pr - cr) + 1;
        ru = du * kc - dv * ks;
        rv = du * ks + dv * kc;
        // floor((r/2^F - 1)/2) via arithmetic shift of the exact value
        src_col = int'(((ru - half) >>> (TRIG_FRAC_BITS + 1)) + cc);
        src_row = int'(((rv - half) >>> (TRIG_FRAC_BITS + 1)) + cr);
        // widths above the store size act as the store size
        w = c.width;
        h = c.height;
        if (w > MAX_SIDE) w = MAX_SIDE;
        if (h > MAX_SIDE) h = MAX_SIDE;
        return src_col >= 0 && src_col < w && src_row >= 0 && src_row < h;
    endfunction

endpackage

// ===== tb/sv/imrot_checker.sv =====
// Checker for the image rotator: tracks register writes and request transactions,
// predicts each fetch result and compares it with the result channel.
// Depends on imrot_pkg, imrot_tb_pkg and the channel interfaces.
module imrot_checker
    import imrot_pkg::*;
    import imrot_tb_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    imrot_req_if                  req,
    imrot_res_if                  res,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    input  logic                  pready,
    output int                    errors,
    output int                    pending
);

    typedef struct packed {
        logic [PIXEL_BITS-1:0] pixel;
        logic                  in_frame;
    } rot_result_t;

    logic [PIXEL_BITS-1:0] frame_mem [0:(1 << ADDR_W)-1];
    logic [PIXEL_BITS-1:0] background;
    rot_cfg_t              cfg;
    rot_result_t           expected_q[$];
    int                    fail_count;
    int                    n_results;

    task automatic report_mismatch(input string what, input logic [PIXEL_BITS-1:0] want_v,
                                   input logic [PIXEL_BITS-1:0] got_v);
        fail_count++;
        if (fail_count <= 10)
            $display("mismatch: %s at result %0d: expected %h, got %h",
                     what, n_results, want_v, got_v);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        rot_result_t want;
        int          sc;
        int          sr;
        bit          hit;
        if (!rst_n)
        begin
            cfg        = cfg_reset();
            background = '0;
            expected_q.delete();
            fail_count = 0;
            n_results  = 0;
            errors  <= 0;
            pending <= 0;
        end
        else
        begin
            // compare a result transaction with the oldest prediction
            if (res.valid && res.ready)
            begin
                if (expected_q.size() == 0)
                    report_mismatch("result with nothing pending", 'x, res.pixel_out);
                else
                begin
                    want = expected_q.pop_front();
                    if (res.pixel_out !== want.pixel)
                        report_mismatch("pixel_out", want.pixel, res.pixel_out);
                    if (res.inside_res !== want.in_frame)
                        report_mismatch("inside_res", PIXEL_BITS'(want.in_frame),
                                        PIXEL_BITS'(res.inside_res));
                end
                n_results++;
            end

            // track register writes
            if (psel && penable && pwrite && pready)
            begin
                case (cfg_reg_t'(paddr[APB_ADDR_W-1:2]))
                    REG_COS:          cfg.cos_v      = pwdata[TRIG_W-1:0];
                    REG_SIN:          cfg.sin_v      = pwdata[TRIG_W-1:0];
                    REG_CENTER_COL:   cfg.center_col = pwdata[COORD_W-1:0];
                    REG_CENTER_ROW:   cfg.center_row = pwdata[COORD_W-1:0];
                    REG_FRAME_WIDTH:  cfg.width      = pwdata[SIDE_W-1:0];
                    REG_FRAME_HEIGHT: cfg.height     = pwdata[SIDE_W-1:0];
                    default: ;
                endcase
            end

            // apply a request transaction: store a load, predict a fetch
            if (req.valid && req.ready)
            begin
                if (req_kind_t'(req.req_type) == REQ_LOAD)
                begin
                    frame_mem[{req.row, req.col}] = req.pixel_in;
                    // loading the last row, first column refreshes the background
                    if (req.col == 0 && cfg.height != 0
                        && int'(req.row) == int'(cfg.height) - 1)
                        background = req.pixel_in;
                end
                else
                begin
                    hit = map_source(cfg, req.col, req.row, sc, sr);
                    want.in_frame = hit;
                    want.pixel    = hit ? frame_mem[{COORD_W'(sr), COORD_W'(sc)}] : background;
                    expected_q.push_back(want);
                end
            end

            errors  <= fail_count;
            pending <= expected_q.size();
        end
    end

endmodule

// ===== tb/sv/testbench.sv =====
// Top of the image rotator testbench: clock, reset, register writes and request
// and result traffic; the checker predicts and compares. Depends on imrot_pkg,
// imrot_tb_pkg, the channel interfaces, imrot_checker and image_rotate_nearest.
module testbench;
    import imrot_pkg::*;
    import imrot_tb_pkg::*;

    localparam logic [COORD_W-1:0] LAST_COORD = COORD_W'(MAX_SIDE - 1);

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    int                    errors;
    int                    pending;

    imrot_req_if req_ch();
    imrot_res_if res_ch();

    image_rotate_nearest DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req_ch),
        .res     (res_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    imrot_checker chk (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req_ch),
        .res     (res_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .pready  (pready),
        .errors  (errors),
        .pending (pending)
    );

    // Stimulus-side view of the registers and of which store entries hold data
    rot_cfg_t cfg;
    bit       loaded [0:(1 << ADDR_W)-1];
    bit       send_quiet;
    bit       recv_quiet;
    int       n_loads;
    int       n_fetches;
    int       n_inside;
    int       n_settings;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Hard stop in case the run hangs
    initial
    begin
        #5_000_000;
        $display("testbench: FAIL");
        $finish;
    end

    // Result side: stall a random number of cycles before taking each transaction
    initial
    begin
        int stall;
        res_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = recv_quiet ? 0 : $urandom_range(0, 14);
            if (stall > 0)
            begin
                @(negedge clk) res_ch.ready <= 1'b0;
                repeat (stall - 1) @(negedge clk);
            end
            @(negedge clk) res_ch.ready <= 1'b1;
            do @(posedge clk); while (!(res_ch.valid && res_ch.ready));
        end
    end

    // Send one request transaction after a random gap
    task automatic send_item(input req_kind_t kind, input logic [COORD_W-1:0] c,
                             input logic [COORD_W-1:0] r, input logic [PIXEL_BITS-1:0] px);
        int gap;
        gap = send_quiet ? 0 : $urandom_range(0, 14);
        if (gap > 0)
        begin
            @(negedge clk) req_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        req_ch.valid    <= 1'b1;
        req_ch.req_type <= kind;
        req_ch.col      <= c;
        req_ch.row      <= r;
        req_ch.pixel_in <= px;
        do @(posedge clk); while (!(req_ch.valid && req_ch.ready));
        if (kind == REQ_LOAD)
        begin
            loaded[{r, c}] = 1'b1;
            n_loads++;
        end
        else
            n_fetches++;
    endtask

    // Fetch a destination pixel; load its source first if that entry is still empty
    task automatic fetch_pixel(input logic [COORD_W-1:0] c, input logic [COORD_W-1:0] r);
        int sc;
        int sr;
        bit hit;
        hit = map_source(cfg, c, r, sc, sr);
        if (hit && !loaded[{COORD_W'(sr), COORD_W'(sc)}])
            send_item(REQ_LOAD, COORD_W'(sc), COORD_W'(sr), $urandom());
        send_item(REQ_FETCH, c, r, $urandom());
        if (hit)
            n_inside++;
    endtask

    // Drop valid and hold until every result is in and the pipeline is empty
    task automatic drain_results();
        @(negedge clk) req_ch.valid <= 1'b0;
        while (pending != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // Write all registers with the block idle
    task automatic apply_config(input rot_cfg_t next);
        logic [APB_DATA_W-1:0] data;
        cfg_reg_t              idx;
        drain_results();
        for (int i = REG_COS; i <= REG_FRAME_HEIGHT; i++)
        begin
            idx  = cfg_reg_t'(i);
            data = '0;
            case (idx)
                REG_COS:          data[TRIG_W-1:0]  = next.cos_v;
                REG_SIN:          data[TRIG_W-1:0]  = next.sin_v;
                REG_CENTER_COL:   data[COORD_W-1:0] = next.center_col;
                REG_CENTER_ROW:   data[COORD_W-1:0] = next.center_row;
                REG_FRAME_WIDTH:  data[SIDE_W-1:0]  = next.width;
                REG_FRAME_HEIGHT: data[SIDE_W-1:0]  = next.height;
                default: ;
            endcase
            // setup cycle, then access cycle
            @(negedge clk);
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= 1'b1;
            paddr   <= APB_ADDR_W'({idx, 2'b00});
            pwdata  <= data;
            @(negedge clk) penable <= 1'b1;
            @(negedge clk);
            psel    <= 1'b0;
            penable <= 1'b0;
            pwrite  <= 1'b0;
        end
        cfg = next;
        n_settings++;
    endtask

    function automatic rot_cfg_t make_cfg(input int cos_v, input int sin_v,
                                          input int ccol, input int crow,
                                          input int w, input int h);
        rot_cfg_t c;
        c.cos_v      = TRIG_W'(cos_v);
        c.sin_v      = TRIG_W'(sin_v);
        c.center_col = COORD_W'(ccol);
        c.center_row = COORD_W'(crow);
        c.width      = SIDE_W'(w);
        c.height     = SIDE_W'(h);
        return c;
    endfunction

    // Frame side: mostly small, sometimes large, now and then a single pixel or oversized
    function automatic logic [SIDE_W-1:0] draw_side();
        case ($urandom_range(0, 9))
            6, 7:    return SIDE_W'($urandom_range(33, MAX_SIDE));
            8:       return SIDE_W'(MAX_SIDE);
            9:       return $urandom_range(0, 1) ? SIDE_W'(1) : {SIDE_W{1'b1}};
            default: return SIDE_W'($urandom_range(1, 32));
        endcase
    endfunction

    // Coordinate within span of a centre, clamped to the store
    function automatic logic [COORD_W-1:0] near_coord(input int centre, input int span);
        int t;
        t = centre + int'($urandom_range(0, 2 * span)) - span;
        if (t < 0) t = 0;
        if (t > MAX_SIDE - 1) t = MAX_SIDE - 1;
        return COORD_W'(t);
    endfunction

    // One register setting followed by a random mix of loads and fetches
    task automatic random_phase(input int n_items);
        rot_cfg_t next;
        int       wl;
        int       hl;
        int       span;
        int       pick;
        case ($urandom_range(0, 5))
            0:       begin next.cos_v = TRIG_W'(TRIG_ONE);  next.sin_v = '0;                 end
            1:       begin next.cos_v = '0;                 next.sin_v = TRIG_W'(TRIG_ONE);  end
            2:       begin next.cos_v = TRIG_W'(-TRIG_ONE); next.sin_v = '0;                 end
            3:       begin next.cos_v = '0;                 next.sin_v = TRIG_W'(-TRIG_ONE); end
            default:
            begin
                next.cos_v = TRIG_W'(int'($urandom_range(0, 2 * TRIG_ONE)) - TRIG_ONE);
                next.sin_v = TRIG_W'(int'($urandom_range(0, 2 * TRIG_ONE)) - TRIG_ONE);
            end
        endcase
        next.width  = draw_side();
        next.height = draw_side();
        wl = next.width > MAX_SIDE ? MAX_SIDE : int'(next.width);
        hl = next.height > MAX_SIDE ? MAX_SIDE : int'(next.height);
        // keep the centre over the frame most of the time
        next.center_col = $urandom_range(0, 3) ? COORD_W'($urandom_range(0, wl - 1))
                                               : COORD_W'($urandom());
        next.center_row = $urandom_range(0, 3) ? COORD_W'($urandom_range(0, hl - 1))
                                               : COORD_W'($urandom());
        span = (wl > hl ? wl : hl) + 2;
        apply_config(next);

        for (int k = 0; k < n_items; k++)
        begin
            // switch between idling and back-to-back stretches
            if (k % 50 == 0)
            begin
                send_quiet = ($urandom_range(0, 3) == 0);
                recv_quiet = ($urandom_range(0, 3) == 0);
            end
            // hold off until the result side has caught up
            if (k == n_items / 2)
                drain_results();
            pick = $urandom_range(0, 99);
            if (pick < 30)
                send_item(REQ_LOAD, COORD_W'($urandom_range(0, wl - 1)),
                          COORD_W'($urandom_range(0, hl - 1)), $urandom());
            else if (pick < 35)
                send_item(REQ_LOAD, '0, COORD_W'(next.height - 1), $urandom());
            else if (pick < 45)
                send_item(REQ_LOAD, COORD_W'($urandom()), COORD_W'($urandom()), $urandom());
            else if (pick < 85)
                fetch_pixel(near_coord(next.center_col, span), near_coord(next.center_row, span));
            else
                fetch_pixel(COORD_W'($urandom()), COORD_W'($urandom()));
        end
    endtask

    initial
    begin
        rst_n           = 1'b0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        req_ch.valid    = 1'b0;
        req_ch.req_type = REQ_LOAD;
        req_ch.col      = '0;
        req_ch.row      = '0;
        req_ch.pixel_in = '0;
        cfg             = cfg_reset();
        repeat (12) @(posedge clk);
        @(negedge clk) rst_n <= 1'b1;

        // Identity mapping after reset: corners, background capture at the last row
        send_item(REQ_LOAD, '0, LAST_COORD, 32'hFFFF_FFFF);
        send_item(REQ_LOAD, LAST_COORD, '0, 32'h0000_0000);
        send_item(REQ_LOAD, LAST_COORD, LAST_COORD, 32'hA5A5_A5A5);
        send_item(REQ_LOAD, '0, '0, 32'h5A5A_5A5A);
        fetch_pixel('0, '0);
        fetch_pixel(LAST_COORD, '0);
        fetch_pixel(LAST_COORD, LAST_COORD);
        fetch_pixel('0, LAST_COORD);
        send_item(REQ_LOAD, '0, LAST_COORD, 32'h1234_5678);
        fetch_pixel('0, LAST_COORD);

        // Half turn about the origin: everything maps outside, background returned
        apply_config(make_cfg(-TRIG_ONE, 0, 0, 0, MAX_SIDE, MAX_SIDE));
        fetch_pixel('0, '0);
        fetch_pixel(LAST_COORD, LAST_COORD);

        // Quarter turn about the far corner, oversized frame
        apply_config(make_cfg(0, TRIG_ONE, MAX_SIDE - 1, MAX_SIDE - 1, 1023, 1023));
        fetch_pixel(LAST_COORD, LAST_COORD);
        fetch_pixel('0, '0);

        // Empty frame: no capture, every fetch outside
        apply_config(make_cfg(0, -TRIG_ONE, 0, MAX_SIDE - 1, 0, 0));
        send_item(REQ_LOAD, '0, LAST_COORD, 32'hDEAD_BEEF);
        fetch_pixel('0, LAST_COORD);
        fetch_pixel(COORD_W'(5), COORD_W'(5));

        // Single-pixel frame: that pixel is also the background
        apply_config(make_cfg(TRIG_ONE, 0, 0, 0, 1, 1));
        send_item(REQ_LOAD, '0, '0, 32'h8000_0001);
        fetch_pixel('0, '0);
        fetch_pixel(COORD_W'(1), '0);

        for (int p = 0; p < 12; p++)
            random_phase(150);

        drain_results();
        $display("summary: %0d loads, %0d fetches (%0d mapped inside the frame), %0d settings",
                 n_loads, n_fetches, n_inside, n_settings);
        if (errors == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule
